>>> rtl/edb_pkg.sv
// ----------------------------------------------------------------------------
// edb_pkg
// Shared types and constants for the edit distance best match core.
// ----------------------------------------------------------------------------
`default_nettype none

package edb_pkg;

	localparam int MAX_LEN_DEF    = 32;
	localparam int INDEX_BITS_DEF = 16;
	// column values stay below 64 for any supported length; one spare bit for +1
	localparam int DIST_W         = 7;
	localparam int CFG_W          = 6;
	localparam int OP_W           = 2;
	localparam int CHAR_W         = 8;
	localparam int OUT_W          = 32;
	localparam logic [CFG_W-1:0] MAX_DIFF_RST = CFG_W'(2);
	localparam logic [5:0]       BEST_RST     = 6'h3f;

	typedef enum logic [OP_W-1:0] {
		OP_KEY  = 2'd0,
		OP_WORD = 2'd1,
		OP_END  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// wavefront token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              init;
		logic [CHAR_W-1:0] ch;
		logic [DIST_W-1:0] left;
		logic [DIST_W-1:0] diag;
	} tok_t;

endpackage

`default_nettype wire

>>> rtl/edb_cell.sv
// ----------------------------------------------------------------------------
// edb_cell
// One keyword position: holds its keyword byte and DP column entry, updates
// the entry when a token passes and forwards the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_cell #(
	parameter int IDX = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        kchar_we,
	input  wire logic [edb_pkg::CHAR_W-1:0]  kchar_in,
	input  wire edb_pkg::tok_t               tok_in,
	output edb_pkg::tok_t                    tok_out,
	output logic [edb_pkg::DIST_W-1:0]       dval
);
	import edb_pkg::*;

	logic [CHAR_W-1:0] kchar_q;
	logic [DIST_W-1:0] d_q;
	logic [DIST_W-1:0] up, a, b, c, m, nxt;
	tok_t              tok_s1;

	always_comb begin
		up  = tok_in.init ? DIST_W'(IDX) : d_q;
		a   = tok_in.left + DIST_W'(1);
		b   = up + DIST_W'(1);
		c   = tok_in.diag + ((kchar_q == tok_in.ch) ? DIST_W'(0) : DIST_W'(1));
		m   = (a < b) ? a : b;
		nxt = (m < c) ? m : c;
	end

	always_ff @(posedge clk) begin
		if (kchar_we) begin
			kchar_q <= kchar_in;
		end
		if (tok_in.valid) begin
			d_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1.valid <= tok_in.valid;
			tok_s1.init  <= tok_in.init;
			tok_s1.ch    <= tok_in.ch;
			tok_s1.left  <= nxt;
			tok_s1.diag  <= up;
		end
	end

	assign tok_out = tok_s1;
	assign dval    = d_q;

endmodule

`default_nettype wire

>>> rtl/edit_distance_best_match_core.sv
// ----------------------------------------------------------------------------
// edit_distance_best_match_core
// Nearest dictionary word to a keyword by Levenshtein distance, computed on
// a skewed row of cells, one per keyword position.
// ----------------------------------------------------------------------------
// channel  dir  handshake          contents
// s_*      in   tvalid/tready      tdata=character, tuser=operation, tlast=last
// m_*      out  tvalid/tready      tdata=result fields
// cfg_*    in   valid/ready        max_length_difference
//
// Word bytes are taken one per cycle while no scoring is pending; the token
// walks the cell row one cell per cycle. A final word byte holds the input
// until the wavefront reaches the last keyword cell, then the word is scored.
// Keyword bytes and end of dictionary wait until the row has drained.
// End of dictionary waits while a previous result is not yet taken.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_best_match_core #(
	parameter int MAX_LEN    = edb_pkg::MAX_LEN_DEF,
	parameter int INDEX_BITS = edb_pkg::INDEX_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [edb_pkg::CHAR_W-1:0] s_tdata,  // [7:0] character
	input  wire logic [edb_pkg::OP_W-1:0]   s_tuser,  // [1:0] operation
	input  wire logic                       s_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [0] exact_found, [1] match_found, [17:2] best_index,
	// [23:18] best_distance, [24] truncated, [31:25] zero
	output logic [edb_pkg::OUT_W-1:0]       m_tdata,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [edb_pkg::CFG_W-1:0]  cfg_data
);
	import edb_pkg::*;

	localparam int KW = $clog2(MAX_LEN + 1);

	logic [CFG_W-1:0]      max_diff_q;
	logic [KW-1:0]         klen_q, wl_q, drain_q, widx;
	logic                  kdone_q, exact_q, found_q, trunc_q, pend_q;
	logic [INDEX_BITS-1:0] pos_q, best_pos_q;
	logic [5:0]            best_q;
	logic [DIST_W-1:0]     col0_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_q;

	tok_t                  tok   [MAX_LEN+1];
	logic [DIST_W-1:0]     dist_arr [MAX_LEN+1];

	op_t                   op;
	logic                  acc, kw_wr, tok_go, do_score, pass;
	logic [DIST_W-1:0]     dsel;
	logic [6:0]            diff;

	assign op = op_t'(s_tuser);

	always_comb begin
		s_tready = !pend_q;
		if (op != OP_WORD && drain_q != '0) begin
			s_tready = 1'b0;
		end
		if (op == OP_END && out_valid_q) begin
			s_tready = 1'b0;
		end
	end

	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign widx      = kdone_q ? '0 : klen_q;
	assign kw_wr     = acc && op == OP_KEY && widx < KW'(MAX_LEN);
	assign tok_go    = acc && op == OP_WORD && !exact_q && wl_q < KW'(MAX_LEN);
	assign do_score  = pend_q && drain_q == '0;

	assign dist_arr[0] = col0_q;
	assign dsel        = dist_arr[klen_q];
	assign diff        = (klen_q > wl_q) ? 7'(klen_q - wl_q) : 7'(wl_q - klen_q);
	assign pass        = diff <= 7'(max_diff_q);

	always_comb begin
		tok[0].valid = tok_go;
		tok[0].init  = wl_q == '0;
		tok[0].ch    = s_tdata;
		tok[0].left  = DIST_W'(wl_q) + DIST_W'(1);
		tok[0].diag  = (wl_q == '0) ? '0 : col0_q;
	end

	for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
		edb_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.kchar_we (kw_wr && widx == KW'(i - 1)),
			.kchar_in (s_tdata),
			.tok_in   (tok[i-1]),
			.tok_out  (tok[i]),
			.dval     (dist_arr[i])
		);
	end

	always_ff @(posedge clk) begin
		if (tok_go) begin
			col0_q <= DIST_W'(wl_q) + DIST_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_diff_q  <= MAX_DIFF_RST;
			klen_q      <= '0;
			kdone_q     <= 1'b1;
			wl_q        <= '0;
			pos_q       <= '0;
			best_q      <= BEST_RST;
			best_pos_q  <= '0;
			exact_q     <= 1'b0;
			found_q     <= 1'b0;
			trunc_q     <= 1'b0;
			pend_q      <= 1'b0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_diff_q <= cfg_data;
			end
			if (m_tready && !(acc && op == OP_END)) begin
				out_valid_q <= 1'b0;
			end
			if (drain_q != '0 && !tok_go) begin
				drain_q <= drain_q - KW'(1);
			end
			if (do_score) begin
				pend_q <= 1'b0;
				wl_q   <= '0;
				pos_q  <= pos_q + INDEX_BITS'(1);
				if (pass) begin
					if (dsel == '0) begin
						exact_q    <= 1'b1;
						found_q    <= 1'b1;
						best_q     <= '0;
						best_pos_q <= pos_q;
					end else if (!found_q || 6'(dsel) < best_q) begin
						found_q    <= 1'b1;
						best_q     <= 6'(dsel);
						best_pos_q <= pos_q;
					end
				end
			end
			if (acc) begin
				unique case (op)
					OP_KEY: begin
						if (kdone_q) begin
							wl_q       <= '0;
							pos_q      <= '0;
							best_q     <= BEST_RST;
							best_pos_q <= '0;
							exact_q    <= 1'b0;
							found_q    <= 1'b0;
							trunc_q    <= 1'b0;
						end else if (widx >= KW'(MAX_LEN)) begin
							trunc_q <= 1'b1;
						end
						klen_q  <= (widx < KW'(MAX_LEN)) ? widx + KW'(1) : widx;
						kdone_q <= s_tlast;
					end
					OP_WORD: begin
						kdone_q <= 1'b1;
						if (exact_q) begin
							if (s_tlast) begin
								wl_q  <= '0;
								pos_q <= pos_q + INDEX_BITS'(1);
							end
						end else begin
							if (tok_go) begin
								wl_q    <= wl_q + KW'(1);
								drain_q <= klen_q;
							end else begin
								trunc_q <= 1'b1;
							end
							if (s_tlast) begin
								pend_q <= 1'b1;
							end
						end
					end
					OP_END: begin
						out_valid_q <= 1'b1;
						out_q       <= {7'd0, trunc_q, found_q ? best_q : 6'd0,
							found_q ? 16'(best_pos_q) : 16'd0, found_q, exact_q};
						kdone_q     <= 1'b1;
						wl_q        <= '0;
						pos_q       <= '0;
						best_q      <= BEST_RST;
						best_pos_q  <= '0;
						exact_q     <= 1'b0;
						found_q     <= 1'b0;
						trunc_q     <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q <= klen_q) else $error("drain count beyond keyword length");
	a_exact_best: assert property (@(posedge clk) disable iff (!arst_n)
		exact_q |-> (found_q && best_q == 6'd0)) else $error("exact without zero best");
	a_pend_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s_tready) else $error("input taken while scoring pending");
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_END) |=> (!found_q && !exact_q && m_tvalid))
		else $error("search not cleared at end of dictionary");

endmodule

`default_nettype wire

>>> dv/edit_distance_best_match_core_test.sv
// ----------------------------------------------------------------------------
// edit_distance_best_match_core_test
// Drives keyword and dictionary streams into the core, predicts the best
// match summary per dictionary and compares every result transfer with it.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_best_match_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import edb_pkg::*;

	localparam int KLEN = 32;

	// packed from the top bit down, so exact lands in bit 0
	typedef struct packed {
		logic        trunc;
		logic [5:0]  distance;
		logic [15:0] index;
		logic        found;
		logic        exact;
	} summary_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	edit_distance_best_match_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [5:0]  max_diff;
	logic [7:0]  kw [KLEN];
	int          kw_len;
	bit          kw_done;
	int          col [KLEN+1];
	int          w_len;
	logic [15:0] w_pos;
	int          best_dist;
	logic [15:0] best_pos;
	bit          f_exact, f_found, f_trunc;

	summary_t    summary_q[$];
	int          send_idle_pct, recv_idle_pct;
	bit          hold_off;
	int          errors, mismatches, n_items, n_results, n_exact, n_trunc;

	function automatic void clear_search();
		w_len = 0; w_pos = '0; best_dist = 63; best_pos = '0;
		f_exact = 0; f_found = 0; f_trunc = 0;
	endfunction

	function automatic void finish_word();
		int diff;
		diff = kw_len > w_len ? kw_len - w_len : w_len - kw_len;
		if (diff <= int'(max_diff)) begin
			if (col[kw_len] == 0) begin
				f_exact = 1; f_found = 1; best_dist = 0; best_pos = w_pos;
			end else if (!f_found || col[kw_len] < best_dist) begin
				f_found = 1; best_dist = col[kw_len]; best_pos = w_pos;
			end
		end
		w_pos++;
		w_len = 0;
	endfunction

	function automatic void predict_item(op_t op, logic [7:0] ch, bit last);
		summary_t s;
		int diag, up, m;
		case (op)
			OP_KEY: begin
				if (kw_done) begin
					kw_done = 0; kw_len = 0; clear_search();
				end
				if (kw_len < KLEN) begin
					kw[kw_len] = ch; kw_len++;
				end else f_trunc = 1;
				if (last) kw_done = 1;
			end
			OP_WORD: begin
				kw_done = 1;
				if (f_exact) begin
					if (last) begin
						w_pos++; w_len = 0;
					end
				end else begin
					if (w_len < KLEN) begin
						if (w_len == 0) for (int i = 0; i <= kw_len; i++) col[i] = i;
						diag = col[0];
						col[0] = w_len + 1;
						for (int i = 1; i <= kw_len; i++) begin
							up = col[i];
							m = col[i-1] + 1;
							if (up + 1 < m) m = up + 1;
							if (diag + (kw[i-1] == ch ? 0 : 1) < m)
								m = diag + (kw[i-1] == ch ? 0 : 1);
							col[i] = m;
							diag = up;
						end
						w_len++;
					end else f_trunc = 1;
					if (last) finish_word();
				end
			end
			OP_END: begin
				s.exact    = f_exact;
				s.found    = f_found;
				s.index    = f_found ? best_pos : '0;
				s.distance = f_found ? 6'(best_dist) : '0;
				s.trunc    = f_trunc;
				summary_q.insert(summary_q.size(), s);
				if (f_exact) n_exact++;
				if (f_trunc) n_trunc++;
				kw_done = 1;
				clear_search();
			end
			default: ;
		endcase
	endfunction

	// valid stays up after the transfer; the next item or wait_drained takes it down
	task automatic send_item(op_t op, logic [7:0] ch, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= ch;
		s_tlast  <= last;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		predict_item(op, ch, last);
		n_items++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (summary_q.size() != 0) @(posedge clk);
		repeat (KLEN + 8) @(posedge clk);
	endtask

	task automatic write_max_diff(logic [5:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		max_diff = v;
	endtask

	task automatic send_keyword(int len, int alpha);
		for (int i = 0; i < len; i++)
			send_item(OP_KEY, 8'($urandom_range(alpha - 1)) + 8'h61, i == len - 1);
	endtask

	// word either copied from keyword with a few edits or random
	task automatic send_word(int len, int alpha);
		logic [7:0] ch;
		bit copy;
		copy = $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			if (copy && i < kw_len && $urandom_range(4) != 0) ch = kw[i];
			else ch = 8'($urandom_range(alpha - 1)) + 8'h61;
			send_item(OP_WORD, ch, i == len - 1);
		end
	endtask

	task automatic random_dictionary();
		int klen, nw, alpha, wlen;
		alpha = $urandom_range(4) == 0 ? 256 : $urandom_range(2, 4);
		if (alpha == 256) alpha = 159;
		klen = $urandom_range(9) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 6);
		if ($urandom_range(9) != 0) send_keyword(klen, alpha);
		nw = $urandom_range(1, 6);
		for (int w = 0; w < nw; w++) begin
			if ($urandom_range(19) == 0)
				send_item(op_t'(OP_NONE), 8'($urandom), $urandom_range(1));
			if ($urandom_range(9) == 0) begin
				wlen = $urandom_range(30, 36);
			end else begin
				wlen = kw_len + int'($urandom_range(4)) - 2;
				if (wlen < 1) wlen = 1;
			end
			send_word(wlen, alpha);
		end
		send_item(OP_END, 8'($urandom), $urandom_range(1));
	endtask

	task automatic test_directed();
		send_keyword(3, 3);
		send_item(OP_WORD, 8'h00, 1);
		send_item(OP_WORD, kw[0], 0); send_item(OP_WORD, kw[1], 0);
		send_item(OP_WORD, kw[2], 1);
		send_item(OP_WORD, 8'hff, 1);
		send_item(OP_END, 8'hff, 1);
		send_item(OP_END, 8'h00, 0);
		// keyword interrupted by a two-byte word, then overlong word
		send_item(OP_KEY, 8'hff, 0);
		send_item(OP_KEY, 8'h00, 0);
		send_item(OP_WORD, 8'hff, 0);
		send_item(OP_WORD, 8'h00, 1);
		for (int i = 0; i < 34; i++) send_item(OP_WORD, 8'haa, i == 33);
		send_item(op_t'(OP_NONE), 8'h55, 1);
		send_item(OP_END, 8'h00, 1);
		for (int i = 0; i < 34; i++) send_item(OP_KEY, 8'h5a, i == 33);
		send_item(OP_END, 8'h00, 0);
	endtask

	task automatic test_length_filter();
		logic [5:0] vals[4] = '{6'd0, 6'd32, 6'd63, 6'd1};
		foreach (vals[k]) begin
			write_max_diff(vals[k]);
			repeat (8) random_dictionary();
		end
		write_max_diff(6'd2);
	endtask

	// the receiver process ends the hold-off after its stretch
	task automatic test_backpressure();
		hold_off = 1;
		repeat (3) random_dictionary();
	endtask

	task automatic test_random(int target);
		while (n_items < target) random_dictionary();
	endtask

	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				for (hold = 0; hold < 400; hold++) @(posedge clk);
				hold_off = 0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		summary_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[24:0];
			n_results++;
			if (summary_q.size() == 0) begin
				errors++;
				$display("unexpected result transfer %h", m_tdata);
			end else begin
				want = summary_q.pop_front();
				if (got != want || m_tdata[31:25] != '0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x%0d f%0d i%0d d%0d t%0d, got %h",
							want.exact, want.found, want.index, want.distance, want.trunc,
							m_tdata);
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("edit_distance_best_match_core_test failed");
		$finish;
	end

	initial begin
		max_diff = 6'd2; kw_len = 0; kw_done = 1; hold_off = 0;
		foreach (col[i]) col[i] = 0;
		clear_search();
		send_idle_pct = 16; recv_idle_pct = 83;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_length_filter();
		test_backpressure();
		test_random(500);
		send_idle_pct = 83; recv_idle_pct = 16;
		test_random(900);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(1350);
		wait_drained();
		$display("%0d input transfers, %0d summaries (%0d exact, %0d truncated)",
			n_items, n_results, n_exact, n_trunc);
		if (errors == 0 && summary_q.size() == 0)
			$display("edit_distance_best_match_core_test passed");
		else
			$display("edit_distance_best_match_core_test failed");
		$finish;
	end

endmodule

`default_nettype wire
